// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the local-history predictor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lhbp_pkg.sv -----
// Package with the shared types, codes and counter rule of the local-history predictor.
`timescale 1ns / 1ps

package lhbp_pkg;

    localparam int ADDR_W  = 64;
    // The address is folded as four equal chunks.
    localparam int CHUNK_W = ADDR_W / 4;

    typedef logic [1:0] ctr_t;

    localparam ctr_t CTR_SNT = 2'd0;
    localparam ctr_t CTR_WNT = 2'd1;
    localparam ctr_t CTR_WT  = 2'd2;
    localparam ctr_t CTR_ST  = 2'd3;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_HIST_RD,
        ST_CTR_RD,
        ST_FINISH
    } state_t;

    // Skewed step: a taken branch lifts either not-taken state straight to weakly taken.
    function automatic ctr_t counter_step(input ctr_t c, input logic taken);
        ctr_t n;
        case (c)
            CTR_SNT, CTR_WNT: n = taken ? CTR_WT : CTR_SNT;
            CTR_WT:           n = taken ? CTR_ST : CTR_WNT;
            default:          n = taken ? CTR_ST : CTR_WT;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/local_history_branch_predictor_top.sv -----
// Top level of the two-level local-history branch direction predictor.
`timescale 1ns / 1ps

// Two-level local-history direction predictor. Raise start with opcode, branch_address
// and taken_outcome while busy is low; the beat is taken at that edge. The address is
// reduced modulo NUM_HISTORY_REGS by a pipeline that folds its 16-bit chunks with
// constant weights and finishes with a reciprocal multiplication, after which the
// history memory and then the counter memory are each read through a registered port,
// and done pulses for one cycle, carrying predict_taken (always 0 for an update). busy
// stays high until that cycle ends; the next beat can be taken on the cycle after done,
// so no new beat is accepted while the previous one is in flight. The receiver cannot
// stall, so done must be sampled when it is high. After reset both memories are
// cleared by a sweep over the counter table, during which busy is high.
module local_history_branch_predictor_top #(
    parameter int NUM_HISTORY_REGS = 16,
    parameter int TABLE_SIZE       = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [lhbp_pkg::ADDR_W-1:0] branch_address,
    input  logic                        taken_outcome,
    output logic                        done,
    output logic                        predict_taken
);

    import lhbp_pkg::*;
    `include "assert_macros.svh"

    localparam int REG_W     = (NUM_HISTORY_REGS > 1) ? $clog2(NUM_HISTORY_REGS) : 1;
    localparam int HW        = $clog2(TABLE_SIZE);
    localparam int CTR_DEPTH = NUM_HISTORY_REGS * TABLE_SIZE;
    localparam int CIDX_W    = $clog2(CTR_DEPTH);

    localparam logic [HW-1:0]   HIST_MASK = HW'(TABLE_SIZE - 1);
    localparam logic [CIDX_W:0] TS_C      = (CIDX_W + 1)'(TABLE_SIZE);
    localparam logic [CIDX_W:0] NH_C      = (CIDX_W + 1)'(NUM_HISTORY_REGS);
    localparam logic [CIDX_W-1:0] CLR_LAST = CIDX_W'(CTR_DEPTH - 1);

    state_t state_reg;
    state_t state_next;

    logic              op_reg;
    logic              taken_reg;
    logic [CIDX_W-1:0] base_reg;
    logic [CIDX_W-1:0] base_next;
    logic [CIDX_W-1:0] idx_reg;
    logic [CIDX_W-1:0] idx_next;
    logic [HW-1:0]     hist_reg;
    logic [CIDX_W-1:0] clr_cnt_reg;
    logic [CIDX_W-1:0] clr_cnt_next;

    logic              accept;
    logic              mod_done;
    logic [REG_W-1:0]  reg_sel;

    logic              hist_we;
    logic [REG_W-1:0]  hist_waddr;
    logic [HW-1:0]     hist_wdata;
    logic [REG_W-1:0]  hist_raddr;
    logic [HW-1:0]     hist_rdata;

    logic              ctr_we;
    logic [CIDX_W-1:0] ctr_waddr;
    ctr_t              ctr_wdata;
    logic [CIDX_W-1:0] ctr_raddr;
    ctr_t              ctr_rdata;

    logic [CIDX_W:0]   base_prod;
    logic [HW-1:0]     hist_new;

    assign accept = start && !busy;

    lhbp_addr_mod #(
        .NUM_REGS (NUM_HISTORY_REGS),
        .REG_W    (REG_W)
    ) u_addr_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .value (branch_address),
        .rem   (reg_sel),
        .done  (mod_done)
    );

    lhbp_ram #(
        .DEPTH (NUM_HISTORY_REGS),
        .WIDTH (HW),
        .AW    (REG_W)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    lhbp_ram #(
        .DEPTH (CTR_DEPTH),
        .WIDTH ($bits(ctr_t)),
        .AW    (CIDX_W)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    // Row base of the selected history register in the counter table.
    assign base_prod = (CIDX_W + 1)'(reg_sel) * TS_C;
    assign base_next = base_prod[CIDX_W-1:0];
    assign idx_next  = base_reg + CIDX_W'(hist_rdata & HIST_MASK);
    assign hist_new  = ((hist_reg & HIST_MASK) << 1 | HW'(taken_reg)) & HIST_MASK;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mod_done)
                begin
                    state_next = ST_HIST_RD;
                end
            end
            ST_HIST_RD: state_next = ST_CTR_RD;
            ST_CTR_RD:  state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = 1'b1;
        done          = 1'b0;
        predict_taken = 1'b0;
        hist_we       = 1'b0;
        hist_waddr    = reg_sel;
        hist_wdata    = hist_new;
        hist_raddr    = reg_sel;
        ctr_we        = 1'b0;
        ctr_waddr     = idx_reg;
        ctr_wdata     = counter_step(ctr_rdata, taken_reg);
        ctr_raddr     = idx_next;
        clr_cnt_next  = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                ctr_we       = 1'b1;
                ctr_waddr    = clr_cnt_reg;
                ctr_wdata    = CTR_SNT;
                hist_we      = ({1'b0, clr_cnt_reg} < NH_C);
                hist_waddr   = clr_cnt_reg[REG_W-1:0];
                hist_wdata   = '0;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_FINISH:
            begin
                done          = 1'b1;
                predict_taken = (op_reg == OP_PREDICT) && ctr_rdata[1];
                ctr_we        = (op_reg == OP_UPDATE);
                hist_we       = (op_reg == OP_UPDATE);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            taken_reg <= taken_outcome;
        end
        base_reg <= base_next;
        if (state_reg == ST_CTR_RD)
        begin
            idx_reg  <= idx_next;
            hist_reg <= hist_rdata;
        end
    end

    `ASSERT_NEXT(a_accept_busy, accept, busy, "accepted beat did not raise busy")
    `ASSERT_NEXT(a_done_frees, done, !busy, "busy still high after result beat")
    `ASSERT_IMPLY(a_ctr_write_src, ctr_we && (state_reg != ST_CLEAR), done && (op_reg == OP_UPDATE), "counter written outside an update")

endmodule

// ----- rtl/lhbp_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module lhbp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lhbp_addr_mod.sv -----
// Pipelined reduction of the branch address modulo the number of history registers.
`timescale 1ns / 1ps

module lhbp_addr_mod #(
    parameter int NUM_REGS = 16,
    parameter int REG_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [lhbp_pkg::ADDR_W-1:0] value,
    output logic [REG_W-1:0]            rem,
    output logic                        done
);

    import lhbp_pkg::*;

    localparam int PROD_W  = CHUNK_W + REG_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int LOG_N   = $clog2(NUM_REGS);
    localparam int SHIFT   = SUM_W + LOG_N;
    localparam int RECIP_W = SUM_W + 1;
    localparam int QP_W    = SHIFT + SUM_W;

    // Weight of each chunk, that is two to the power of its bit position, taken modulo the register count.
    localparam longint unsigned W1    = (64'd1 << CHUNK_W) % NUM_REGS;
    localparam longint unsigned W2    = (W1 * W1) % NUM_REGS;
    localparam longint unsigned W3    = (W2 * W1) % NUM_REGS;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + NUM_REGS - 1) / NUM_REGS;

    localparam logic [REG_W-1:0]   W1_C    = REG_W'(W1);
    localparam logic [REG_W-1:0]   W2_C    = REG_W'(W2);
    localparam logic [REG_W-1:0]   W3_C    = REG_W'(W3);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [SUM_W-1:0]   N_C     = SUM_W'(NUM_REGS);

    logic [ADDR_W-1:0]  value_reg;
    logic [3:0]         stage_reg;
    logic               done_reg;
    logic [CHUNK_W-1:0] low_reg;
    logic [PROD_W-1:0]  part1_reg;
    logic [PROD_W-1:0]  part2_reg;
    logic [PROD_W-1:0]  part3_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [REG_W-1:0]   rem_reg;
    logic [QP_W-1:0]    quo_prod;
    logic [SUM_W-1:0]   rem_diff;

    // The rounded-up reciprocal gives the exact quotient for every sum the fold can produce.
    assign quo_prod = QP_W'(sum_reg) * QP_W'(RECIP_C);
    assign rem_diff = sum_reg - quo_reg * N_C;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[2:0], load};
            done_reg  <= stage_reg[3];
            if (stage_reg[3])
            begin
                rem_reg <= rem_diff[REG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value;
        end
        if (stage_reg[0])
        begin
            low_reg   <= value_reg[CHUNK_W-1:0];
            part1_reg <= PROD_W'(value_reg[2*CHUNK_W-1:CHUNK_W]) * PROD_W'(W1_C);
            part2_reg <= PROD_W'(value_reg[3*CHUNK_W-1:2*CHUNK_W]) * PROD_W'(W2_C);
            part3_reg <= PROD_W'(value_reg[4*CHUNK_W-1:3*CHUNK_W]) * PROD_W'(W3_C);
        end
        if (stage_reg[1])
        begin
            sum_reg <= SUM_W'(low_reg) + SUM_W'(part1_reg) + SUM_W'(part2_reg)
                       + SUM_W'(part3_reg);
        end
        if (stage_reg[2])
        begin
            quo_reg <= quo_prod[QP_W-1:SHIFT];
        end
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the two-level local-history branch direction predictor.
`timescale 1ns / 1ps

module tb;

    import lhbp_pkg::*;

    localparam int NUM_REGS       = 16;
    localparam int TABLE_DEPTH    = 16;
    localparam int HIST_W         = $clog2(TABLE_DEPTH);
    localparam int SEL_W          = $clog2(NUM_REGS);
    localparam int SLOT_W         = $clog2(NUM_REGS * TABLE_DEPTH);
    localparam int unsigned HIST_MASK = TABLE_DEPTH - 1;
    localparam int WATCHDOG_LIMIT = 4096;
    localparam int DRAIN_CYCLES   = 25;

    typedef struct {
        logic              taken;
        logic              op;
        logic [ADDR_W-1:0] addr;
    } direction_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              opcode = OP_PREDICT;
    logic [ADDR_W-1:0] branch_address = '0;
    logic              taken_outcome = 1'b0;
    logic              busy;
    logic              done;
    logic              predict_taken;

    // Shadow copy of the predictor state.
    logic [HIST_W-1:0] history_shadow [NUM_REGS];
    ctr_t              counter_shadow [NUM_REGS*TABLE_DEPTH];

    direction_t  pending_directions [$];
    int unsigned failures = 0;
    int unsigned quiet_cycles = 0;
    int unsigned predicts_sent = 0;
    int unsigned updates_sent = 0;
    int unsigned taken_predictions = 0;
    int unsigned taken_updates = 0;
    int unsigned results_checked = 0;

    local_history_branch_predictor_top #(
        .NUM_HISTORY_REGS(NUM_REGS),
        .TABLE_SIZE(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .branch_address(branch_address),
        .taken_outcome(taken_outcome),
        .done(done),
        .predict_taken(predict_taken)
    );

    always #1 clk = ~clk;

    // Works out the direction the block should report and trains the shadow state.
    function automatic logic lookup_and_train(input logic op, input logic [ADDR_W-1:0] addr,
                                              input logic taken);
        int unsigned sel;
        int unsigned slot;
        ctr_t        c;
        sel  = 32'(addr % 64'(NUM_REGS));
        slot = (32'(history_shadow[SEL_W'(sel)]) & HIST_MASK) + sel * TABLE_DEPTH;
        c    = counter_shadow[SLOT_W'(slot)];
        if (op == OP_PREDICT)
        begin
            return (c == CTR_WT) || (c == CTR_ST);
        end
        if (taken)
        begin
            counter_shadow[SLOT_W'(slot)] = (c == CTR_WT || c == CTR_ST) ? CTR_ST : CTR_WT;
        end
        else
        begin
            counter_shadow[SLOT_W'(slot)] =
                (c == CTR_ST) ? CTR_WT : (c == CTR_WT) ? CTR_WNT : CTR_SNT;
        end
        history_shadow[SEL_W'(sel)] =
            HIST_W'((((32'(history_shadow[SEL_W'(sel)]) & HIST_MASK) << 1) | 32'(taken))
                    & HIST_MASK);
        return 1'b0;
    endfunction

    function automatic logic [ADDR_W-1:0] address_on(input int unsigned sel);
        logic [ADDR_W-1:0] a;
        a = {$urandom, $urandom};
        return a - (a % 64'(NUM_REGS)) + 64'(sel);
    endfunction

    function automatic logic [ADDR_W-1:0] corner_address();
        logic [ADDR_W-1:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, ADDR_W - 1);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            default: return ~one_hot;
        endcase
    endfunction

    task automatic send_beat(input logic op, input logic [ADDR_W-1:0] addr, input logic taken);
        direction_t e;
        @(negedge clk);
        start          <= 1'b1;
        opcode         <= op;
        branch_address <= addr;
        taken_outcome  <= taken;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        e.op    = op;
        e.addr  = addr;
        e.taken = lookup_and_train(op, addr, taken);
        pending_directions.push_back(e);
        if (op == OP_PREDICT)
        begin
            predicts_sent++;
            taken_predictions += 32'(e.taken);
        end
        else
        begin
            updates_sent++;
            taken_updates += 32'(taken);
        end
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic maybe_pause(input bit allowed);
        if (allowed && $urandom_range(0, 3) == 0)
        begin
            pause_sender($urandom_range(1, 11));
        end
    endtask

    // Address extremes, predicts with the outcome bit set, and counter walks on two registers.
    task automatic test_directed_corners();
        logic [ADDR_W-1:0] on_five;
        logic [ADDR_W-1:0] on_nine;
        on_five = 64'h5555_5555_5555_5555;
        on_nine = 64'h0123_4567_89AB_CDE9;
        send_beat(OP_PREDICT, '0, 1'b0);
        send_beat(OP_PREDICT, '1, 1'b1);
        send_beat(OP_UPDATE, '1, 1'b1);
        maybe_pause(1'b1);
        send_beat(OP_PREDICT, '1, 1'b0);
        send_beat(OP_UPDATE, 64'h8000_0000_0000_000F, 1'b0);
        // Six taken updates fill the history with ones and saturate that counter.
        repeat (6)
        begin
            send_beat(OP_UPDATE, on_five, 1'b1);
            maybe_pause(1'b1);
        end
        send_beat(OP_PREDICT, on_five, 1'b0);
        send_beat(OP_UPDATE, on_five, 1'b0);
        send_beat(OP_PREDICT, on_five, 1'b1);
        // A taken branch, then enough not-taken ones to return to a zero history.
        send_beat(OP_UPDATE, on_nine, 1'b1);
        repeat (5)
        begin
            send_beat(OP_UPDATE, on_nine, 1'b0);
        end
        send_beat(OP_PREDICT, on_nine, 1'b0);
        send_beat(OP_UPDATE, on_nine, 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned beats);
        int unsigned hot [3];
        bit          idling;
        logic [ADDR_W-1:0] addr;
        int unsigned pick;
        for (int unsigned i = 0; i < beats; i++)
        begin
            if (i % 50 == 0)
            begin
                idling = ((i / 50) % 2 == 0);
                foreach (hot[k])
                begin
                    hot[k] = $urandom_range(0, NUM_REGS - 1);
                end
            end
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                addr = address_on(hot[2'($urandom_range(0, 2))]);
            end
            else if (pick == 8)
            begin
                addr = {$urandom, $urandom};
            end
            else
            begin
                addr = corner_address();
            end
            send_beat($urandom_range(0, 1) ? OP_UPDATE : OP_PREDICT, addr,
                      $urandom_range(0, 9) < 7);
            maybe_pause(idling);
        end
    endtask

    // Periodic outcomes on one register, each update preceded by a predict, with some noise.
    task automatic test_trained_patterns(input int unsigned rounds);
        int unsigned period;
        int unsigned sel;
        logic [3:0]  pattern;
        for (int unsigned r = 0; r < rounds; r++)
        begin
            period  = $urandom_range(1, 4);
            pattern = 4'($urandom);
            sel     = $urandom_range(0, NUM_REGS - 1);
            for (int unsigned i = 0; i < 17; i++)
            begin
                send_beat(OP_PREDICT, address_on(sel), 1'($urandom_range(0, 1)));
                send_beat(OP_UPDATE, address_on(sel), pattern[2'(i % period)]);
                if ($urandom_range(0, 9) == 0)
                begin
                    send_beat($urandom_range(0, 1) ? OP_UPDATE : OP_PREDICT,
                              {$urandom, $urandom}, 1'($urandom_range(0, 1)));
                end
                maybe_pause(r % 3 != 2);
            end
        end
    endtask

    task automatic test_back_to_back(input int unsigned beats);
        int unsigned a;
        int unsigned b;
        a = $urandom_range(0, NUM_REGS - 1);
        b = $urandom_range(0, NUM_REGS - 1);
        for (int unsigned i = 0; i < beats; i++)
        begin
            send_beat($urandom_range(0, 1) ? OP_UPDATE : OP_PREDICT,
                      address_on($urandom_range(0, 1) ? a : b), 1'($urandom_range(0, 1)));
        end
    endtask

    always @(posedge clk)
    begin : check_results
        direction_t e;
        if (rst_n && done)
        begin
            if (pending_directions.size() == 0)
            begin
                $error("predict_taken: result %0b arrived with no beat outstanding",
                       predict_taken);
                failures++;
            end
            else
            begin
                e = pending_directions.pop_front();
                results_checked++;
                if (predict_taken !== e.taken)
                begin
                    $error("predict_taken: expected %0b, actual %0b (opcode %0b, address %h)",
                           e.taken, predict_taken, e.op, e.addr);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("local_history_branch_predictor_top: mismatch");
        $finish;
    end

    initial
    begin
        foreach (history_shadow[i])
        begin
            history_shadow[i] = '0;
        end
        foreach (counter_shadow[i])
        begin
            counter_shadow[i] = CTR_SNT;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_random_traffic(900);
        test_trained_patterns(20);
        // Final stretch runs without any gaps between beats.
        test_back_to_back(330);

        @(negedge clk);
        start <= 1'b0;
        while (pending_directions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d predicts (%0d expected taken), %0d updates (%0d taken).",
                 results_checked, predicts_sent, taken_predictions, updates_sent, taken_updates);
        $display("Traffic covered address corners, trained periodic patterns and back-to-back beats.");
        if (failures == 0)
        begin
            $display("local_history_branch_predictor_top: match");
        end
        else
        begin
            $display("local_history_branch_predictor_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lhbp_pkg.sv
rtl/lhbp_ram.sv
rtl/lhbp_addr_mod.sv
rtl/local_history_branch_predictor_top.sv
dv/tb.sv
